// ----- rtl/tcpop_pkg.sv -----
`default_nettype none

package tcpop_pkg;

  // one header byte per input request
  typedef struct packed {
    logic [7:0] header_byte;
    logic       first_byte;
  } in_t;

  // options found in one header
  typedef struct packed {
    logic [15:0] max_segment_size;
    logic [7:0]  window_scale;
    logic        sack_permitted;
    logic        timestamps_present;
  } out_t;

  // parse phase of the open header
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIXED = 3'd1,
    PH_KIND  = 3'd2,
    PH_LEN   = 3'd3,
    PH_BODY  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  // fixed header layout
  localparam logic [5:0] HDR_FIXED_LEN = 6'd20;
  localparam logic [5:0] POS_OFFSET    = 6'd12;
  localparam logic [5:0] POS_FIXED_END = 6'd19;

  // option kinds
  localparam logic [7:0] OPT_EOL     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] OPT_WSCALE  = 8'd3;
  localparam logic [7:0] OPT_SACK_OK = 8'd4;
  localparam logic [7:0] OPT_TSTAMP  = 8'd8;

  // well-formed option lengths
  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [7:0] LEN_MSS     = 8'd4;
  localparam logic [7:0] LEN_WSCALE  = 8'd3;
  localparam logic [7:0] LEN_SACK_OK = 8'd2;
  localparam logic [7:0] LEN_TSTAMP  = 8'd10;

  // what the body of the current option feeds
  localparam logic [7:0] KEEP_SKIP  = 8'd0;
  localparam logic [7:0] KEEP_MSS   = 8'd2;
  localparam logic [7:0] KEEP_SCALE = 8'd3;

endpackage

`default_nettype wire

// ----- rtl/tcp_option_parser_core.sv -----
// TCP header option parser.
// Input channel (in_valid/in_ready/in_data) takes one header byte per request,
// with first_byte set on byte 0. Byte 12 gives the data offset; the option
// area after the fixed 20 bytes is walked for MSS, window scale,
// SACK-permitted and timestamps. One result request (out_valid/out_ready/
// out_data) is issued for the last header byte of each complete header; a
// new first byte abandons an open header without a result, and bytes outside
// any header are dropped.
// Throughput: one byte per cycle while no result waits on a stalled receiver.
// The last byte of a header passes the input register, then the result register,
// before out_valid rises; a result still waiting on the receiver holds it back.
// The per-byte state update is the only loop, one step per byte.
// When the receiver stalls, the result register holds and one more byte is
// buffered in the input register; in_ready falls only when the buffered byte
// would produce a new result. Reset (rst_n low, synchronous) empties both
// registers and returns the parser to idle with no header open.
`default_nettype none

module tcp_option_parser_core (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  tcpop_pkg::in_t   in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output tcpop_pkg::out_t  out_data
);

  import tcpop_pkg::*;

  // input register
  logic        s1_valid_r;
  in_t         s1_data_r;

  // parser state
  phase_t      phase_r,  phase_nxt;
  logic [5:0]  pos_r,    pos_nxt;
  logic [5:0]  hl_r,     hl_nxt;
  logic [7:0]  kind_r,   kind_nxt;
  logic [6:0]  end_r,    end_nxt;
  logic [7:0]  mss_hi_r, mss_hi_nxt;
  logic [15:0] mss_r,    mss_nxt;
  logic [7:0]  scale_r,  scale_nxt;
  logic        sack_r,   sack_nxt;
  logic        ts_r,     ts_nxt;

  // result register
  logic        out_valid_r;
  out_t        out_data_r;

  logic        take;
  logic        emit;
  logic        advance;
  logic        out_free;
  phase_t      ph_cur;
  logic [5:0]  p;
  logic [6:0]  p1;
  logic [6:0]  p2;
  logic [5:0]  start;
  logic [8:0]  opt_end;
  logic [7:0]  b;

  // per-byte state update
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hl_nxt     = hl_r;
    kind_nxt   = kind_r;
    end_nxt    = end_r;
    mss_hi_nxt = mss_hi_r;
    mss_nxt    = mss_r;
    scale_nxt  = scale_r;
    sack_nxt   = sack_r;
    ts_nxt     = ts_r;
    emit       = 1'b0;
    take       = 1'b0;
    ph_cur     = phase_r;
    p          = pos_r;
    b          = s1_data_r.header_byte;

    // a first byte opens a fresh header
    if (s1_data_r.first_byte) begin
      kind_nxt   = KEEP_SKIP;
      end_nxt    = '0;
      mss_hi_nxt = '0;
      mss_nxt    = '0;
      scale_nxt  = '0;
      sack_nxt   = 1'b0;
      ts_nxt     = 1'b0;
      hl_nxt     = '0;
      ph_cur     = PH_FIXED;
      phase_nxt  = PH_FIXED;
      p          = '0;
      take       = 1'b1;
    end else if (phase_r != PH_IDLE) begin
      take = 1'b1;
    end

    p1      = {1'b0, p} + 7'd1;
    p2      = {1'b0, p} + 7'd2;
    start   = p - 6'd1;
    opt_end = {3'b000, start} + {1'b0, b};

    if (take) begin
      case (ph_cur)
        PH_FIXED: begin
          if (p == POS_OFFSET) begin
            hl_nxt = {b[7:4], 2'b00};
          end
          if (p == POS_FIXED_END) begin
            if (hl_nxt > HDR_FIXED_LEN) begin
              phase_nxt = PH_KIND;
            end else begin
              emit = 1'b1;
            end
          end
        end
        PH_KIND: begin
          if (b == OPT_EOL) begin
            phase_nxt = PH_STOP;
          end else if (b != OPT_NOP) begin
            // no room left for a length byte
            if (p1 >= {1'b0, hl_r}) begin
              phase_nxt = PH_STOP;
            end else begin
              kind_nxt  = b;
              phase_nxt = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (b < LEN_MIN || opt_end > {3'b000, hl_r}) begin
            phase_nxt = PH_STOP;
          end else begin
            end_nxt  = opt_end[6:0];
            kind_nxt = KEEP_SKIP;
            if (kind_r == OPT_MSS && b == LEN_MSS) begin
              kind_nxt = KEEP_MSS;
            end else if (kind_r == OPT_WSCALE && b == LEN_WSCALE) begin
              kind_nxt = KEEP_SCALE;
            end else if (kind_r == OPT_SACK_OK && b == LEN_SACK_OK) begin
              sack_nxt = 1'b1;
            end else if (kind_r == OPT_TSTAMP && b == LEN_TSTAMP) begin
              ts_nxt = 1'b1;
            end
            phase_nxt = (b == LEN_MIN) ? PH_KIND : PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind_r == KEEP_MSS) begin
            if (p2 == end_r) begin
              mss_hi_nxt = b;
            end else if (p1 == end_r) begin
              mss_nxt = {mss_hi_r, b};
            end
          end else if (kind_r == KEEP_SCALE) begin
            if (p1 == end_r) begin
              scale_nxt = b;
            end
          end
          if (p1 >= end_r) begin
            phase_nxt = PH_KIND;
          end
        end
        default: begin
        end
      endcase

      // last header byte once options are reached
      if (phase_nxt inside {PH_KIND, PH_LEN, PH_BODY, PH_STOP} &&
          p1 >= {1'b0, hl_nxt}) begin
        emit = 1'b1;
      end

      if (emit) begin
        phase_nxt = PH_IDLE;
        pos_nxt   = '0;
      end else begin
        pos_nxt = p1[5:0];
      end
    end
  end

  // handshake control
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && (out_free || !emit);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      hl_r    <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hl_r    <= hl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r   <= kind_nxt;
      end_r    <= end_nxt;
      mss_hi_r <= mss_hi_nxt;
      mss_r    <= mss_nxt;
      scale_r  <= scale_nxt;
      sack_r   <= sack_nxt;
      ts_r     <= ts_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r.max_segment_size   <= mss_nxt;
      out_data_r.window_scale       <= scale_nxt;
      out_data_r.sack_permitted     <= sack_nxt;
      out_data_r.timestamps_present <= ts_nxt;
    end
  end

  // idle parser always restarts at byte zero
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> pos_r == 6'd0)
    else $error("idle parser with nonzero byte position");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without output backpressure");

  // option phases need a header longer than the fixed part
  a_opt_hl: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KIND || phase_r == PH_LEN || phase_r == PH_BODY ||
     phase_r == PH_STOP) |-> hl_r > HDR_FIXED_LEN)
    else $error("option parsing with no option area");

  // an option body never runs past the header end
  a_body_end: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> end_r <= {1'b0, hl_r})
    else $error("option end beyond header length");

endmodule

`default_nettype wire

// ----- test/tcp_option_parser_core_test.sv -----
`timescale 1ns / 1ps

module tcp_option_parser_core_test;
  import tcpop_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  tcp_option_parser_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // header under construction, one byte per entry
  logic [7:0] frame[$];

  // options expected from each completed header, oldest first
  out_t expected_options[$];

  // parser state as predicted from the accepted bytes
  phase_t     opt_phase;
  logic [5:0] opt_pos;
  logic [5:0] opt_hdr_len;
  logic [7:0] opt_kind_kept;
  logic [6:0] opt_end;
  logic [7:0] mss_hi;
  out_t       found_options;

  out_t want;
  int   mismatches;
  int   items_sent;
  int   stall_cycles;
  bit   sender_idle_on;
  bit   receiver_idle_on;
  bit   long_hold;

  // predict the parser for one accepted header byte
  task automatic track_header_byte(input in_t req);
    int         p;
    int         start;
    logic [7:0] b;
    logic [7:0] kind;
    logic       done;
    b = req.header_byte;
    done = 1'b0;
    if (req.first_byte) begin
      found_options = '0;
      opt_kind_kept = '0;
      opt_end = '0;
      mss_hi = '0;
      opt_hdr_len = '0;
      opt_phase = PH_FIXED;
      p = 0;
    end else begin
      // stray byte with no header open
      if (opt_phase == PH_IDLE) return;
      p = opt_pos;
    end

    case (opt_phase)
      PH_FIXED: begin
        if (p == POS_OFFSET) opt_hdr_len = {b[7:4], 2'b00};
        if (p == POS_FIXED_END) begin
          if (opt_hdr_len > HDR_FIXED_LEN) opt_phase = PH_KIND;
          else done = 1'b1;
        end
      end
      PH_KIND: begin
        if (b == OPT_EOL) begin
          opt_phase = PH_STOP;
        end else if (b != OPT_NOP) begin
          // no room left for a length byte
          if (p + 1 >= opt_hdr_len) begin
            opt_phase = PH_STOP;
          end else begin
            opt_kind_kept = b;
            opt_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        start = p - 1;
        kind = opt_kind_kept;
        if (b < LEN_MIN || start + b > opt_hdr_len) begin
          opt_phase = PH_STOP;
        end else begin
          opt_end = 7'(start + b);
          opt_kind_kept = KEEP_SKIP;
          if (kind == OPT_MSS && b == LEN_MSS) opt_kind_kept = KEEP_MSS;
          else if (kind == OPT_WSCALE && b == LEN_WSCALE) opt_kind_kept = KEEP_SCALE;
          else if (kind == OPT_SACK_OK && b == LEN_SACK_OK) found_options.sack_permitted = 1'b1;
          else if (kind == OPT_TSTAMP && b == LEN_TSTAMP)
            found_options.timestamps_present = 1'b1;
          opt_phase = (b == LEN_MIN) ? PH_KIND : PH_BODY;
        end
      end
      PH_BODY: begin
        if (opt_kind_kept == KEEP_MSS) begin
          if (p + 2 == opt_end) mss_hi = b;
          else if (p + 1 == opt_end) found_options.max_segment_size = {mss_hi, b};
        end else if (opt_kind_kept == KEEP_SCALE) begin
          if (p + 1 == opt_end) found_options.window_scale = b;
        end
        if (p + 1 >= opt_end) opt_phase = PH_KIND;
      end
      default: ;
    endcase

    if (opt_phase >= PH_KIND && p + 1 >= opt_hdr_len) done = 1'b1;

    if (done) begin
      expected_options.push_back(found_options);
      opt_phase = PH_IDLE;
      opt_pos = '0;
    end else begin
      opt_pos = 6'(p + 1);
    end
  endtask

  // predictor runs on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) track_header_byte(in_data);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_options.size() == 0) begin
        $error("result with none expected: mss %0h scale %0h sack %0b ts %0b",
               out_data.max_segment_size, out_data.window_scale,
               out_data.sack_permitted, out_data.timestamps_present);
        mismatches++;
      end else begin
        want = expected_options.pop_front();
        if (out_data.max_segment_size !== want.max_segment_size) begin
          $error("max_segment_size: expected %0h, got %0h",
                 want.max_segment_size, out_data.max_segment_size);
          mismatches++;
        end
        if (out_data.window_scale !== want.window_scale) begin
          $error("window_scale: expected %0h, got %0h",
                 want.window_scale, out_data.window_scale);
          mismatches++;
        end
        if (out_data.sack_permitted !== want.sack_permitted) begin
          $error("sack_permitted: expected %0b, got %0b",
                 want.sack_permitted, out_data.sack_permitted);
          mismatches++;
        end
        if (out_data.timestamps_present !== want.timestamps_present) begin
          $error("timestamps_present: expected %0b, got %0b",
                 want.timestamps_present, out_data.timestamps_present);
          mismatches++;
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    gap = 0;
    if (sender_idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= in_t'{header_byte: value, first_byte: first};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic sender_rest();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // pause the sender until every pending result has come out
  task automatic wait_drained();
    sender_rest();
    wait (expected_options.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // fixed 20 bytes with the given data offset
  task automatic begin_frame(input logic [3:0] offset);
    frame.delete();
    repeat (20) frame.push_back(8'($urandom));
    frame[POS_OFFSET] = {offset, 4'($urandom)};
  endtask

  task automatic put_option(input logic [7:0] kind, input int len);
    frame.push_back(kind);
    frame.push_back(8'(len));
    repeat (len - 2) frame.push_back(8'($urandom));
  endtask

  // walk the option area with random options, some of them malformed
  task automatic fill_options(input bit allow_broken);
    int         total;
    int         rem;
    int         len;
    logic [7:0] kind;
    total = frame[POS_OFFSET][7:4] * 4;
    while (frame.size() < total) begin
      rem = total - frame.size();
      if (allow_broken && $urandom_range(0, 7) == 0) begin
        // short length, length past the end, or kind with no room for a length
        frame.push_back(8'($urandom_range(2, 255)));
        if (rem > 1)
          frame.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(rem + 1, 255)));
        while (frame.size() < total) frame.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 11))
          2, 3: begin kind = OPT_MSS; len = LEN_MSS; end
          4: begin kind = OPT_WSCALE; len = LEN_WSCALE; end
          5: begin kind = OPT_SACK_OK; len = LEN_SACK_OK; end
          6: begin kind = OPT_TSTAMP; len = LEN_TSTAMP; end
          7, 8, 9: begin
            kind = 8'($urandom_range(2, 255));
            len = (rem >= 2) ? $urandom_range(2, rem) : 2;
          end
          10: begin kind = OPT_EOL; len = 0; end
          default: begin kind = OPT_NOP; len = 0; end
        endcase
        if (kind == OPT_EOL) begin
          // end of list, then garbage that must be ignored
          frame.push_back(OPT_EOL);
          while (frame.size() < total) frame.push_back(8'($urandom));
        end else if (kind == OPT_NOP || len > rem) begin
          frame.push_back(OPT_NOP);
        end else begin
          put_option(kind, len);
        end
      end
    end
  endtask

  task automatic send_frame(input int count);
    for (int i = 0; i < count && i < frame.size(); i++) send_byte(frame[i], i == 0);
  endtask

  // data offset of five or less: result at byte 19, all zero
  task automatic test_short_offset();
    begin_frame(4'd5);
    foreach (frame[i]) frame[i] = 8'hFF;
    frame[POS_OFFSET] = 8'h5F;
    send_frame(frame.size());
    begin_frame(4'd0);
    foreach (frame[i]) frame[i] = 8'h00;
    send_frame(frame.size());
  endtask

  // every well-formed option, with extreme values
  task automatic test_known_options();
    begin_frame(4'd10);
    frame.push_back(OPT_MSS);
    frame.push_back(LEN_MSS);
    frame.push_back(8'hFF);
    frame.push_back(8'hFF);
    frame.push_back(OPT_NOP);
    frame.push_back(OPT_WSCALE);
    frame.push_back(LEN_WSCALE);
    frame.push_back(8'hFF);
    put_option(OPT_SACK_OK, LEN_SACK_OK);
    put_option(OPT_TSTAMP, LEN_TSTAMP);
    send_frame(frame.size());
  endtask

  task automatic test_broken_options();
    // length below two stops the walk
    begin_frame(4'd6);
    frame.push_back(8'd7);
    frame.push_back(8'd1);
    frame.push_back(OPT_MSS);
    frame.push_back(LEN_MSS);
    send_frame(frame.size());
    // kind in the last header byte has no room for its length
    begin_frame(4'd6);
    repeat (3) frame.push_back(OPT_NOP);
    frame.push_back(OPT_MSS);
    send_frame(frame.size());
    // wrong length skips mss, sack still taken, end of list then garbage
    begin_frame(4'd7);
    put_option(OPT_MSS, 3);
    put_option(OPT_SACK_OK, LEN_SACK_OK);
    frame.push_back(OPT_EOL);
    frame.push_back(OPT_MSS);
    frame.push_back(LEN_MSS);
    send_frame(frame.size());
    // mss running past the header end
    begin_frame(4'd6);
    frame.push_back(OPT_MSS);
    frame.push_back(8'd5);
    frame.push_back(8'h12);
    frame.push_back(8'h34);
    send_frame(frame.size());
    // later copies overwrite earlier ones, scale of zero kept after a stop
    begin_frame(4'd8);
    frame.push_back(OPT_MSS);
    frame.push_back(LEN_MSS);
    frame.push_back(8'h12);
    frame.push_back(8'h34);
    frame.push_back(OPT_MSS);
    frame.push_back(LEN_MSS);
    frame.push_back(8'h80);
    frame.push_back(8'h01);
    frame.push_back(OPT_WSCALE);
    frame.push_back(LEN_WSCALE);
    frame.push_back(8'h00);
    frame.push_back(8'd0);
    send_frame(frame.size());
  endtask

  task automatic test_stray_and_abandoned();
    // bytes outside any header are dropped
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // header cut in the fixed part, then a complete one
    begin_frame(4'd6);
    send_frame(9);
    begin_frame(4'd6);
    frame.push_back(OPT_WSCALE);
    frame.push_back(LEN_WSCALE);
    frame.push_back(8'h0E);
    frame.push_back(OPT_NOP);
    send_frame(frame.size());
    // header cut inside its options, one byte short of the end
    begin_frame(4'd9);
    fill_options(1'b0);
    send_frame(frame.size() - 1);
    begin_frame(4'd5);
    send_frame(frame.size());
  endtask

  // receiver holds off while headers keep coming, then everything drains
  task automatic test_back_pressure();
    sender_idle_on = 1'b0;
    long_hold = 1'b1;
    repeat (6) begin
      begin_frame(4'd5);
      send_frame(frame.size());
    end
    wait_drained();
    sender_idle_on = 1'b1;
  endtask

  task automatic test_random_headers(input int item_count, input bit with_idle);
    int         first_item;
    logic [3:0] offset;
    first_item = items_sent;
    while (items_sent - first_item < item_count) begin
      sender_idle_on = with_idle && ($urandom_range(0, 3) != 0);
      receiver_idle_on = with_idle && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: offset = 4'($urandom_range(0, 5));
        1: offset = 4'd15;
        default: offset = 4'($urandom_range(6, 10));
      endcase
      begin_frame(offset);
      fill_options($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0, 1: send_frame($urandom_range(1, frame.size() - 1));
        2: repeat ($urandom_range(10, 40)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        3, 4: begin
          send_frame(frame.size());
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end
        default: send_frame(frame.size());
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    opt_phase = PH_IDLE;
    opt_pos = '0;
    opt_hdr_len = '0;
    opt_kind_kept = '0;
    opt_end = '0;
    mss_hi = '0;
    found_options = '0;
    mismatches = 0;
    items_sent = 0;
    stall_cycles = 0;
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    long_hold = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_short_offset();
    test_known_options();
    test_broken_options();
    test_stray_and_abandoned();
    test_back_pressure();
    test_random_headers(680, 1'b1);
    // last stretch runs with no idling on either side
    test_random_headers(150, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tcpop_pkg.sv
rtl/tcp_option_parser_core.sv
test/tcp_option_parser_core_test.sv
